[src/poh_pkg.sv]
// Shared types, constants and helpers of the pyramid orientation histogram.
package poh_pkg;

  localparam int CW        = 10;
  localparam int CNT_W     = 21;
  localparam int BIN_W     = 5;
  localparam int OB_W      = 4;
  localparam int LEV_W     = 2;
  localparam int RI_W      = 11;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int LVL_W     = 3;
  localparam int SH_W      = CW + 1 + (1 << LVL_W) - 1;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 21'd1048576;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS     = 3'd5;

  typedef struct packed {
    logic             start;
    logic [CW-1:0]    dividend;
    logic [CW:0]      divisor;
    logic [LVL_W-1:0] level;
  } poh_div_req_t;

  typedef struct packed {
    logic          done;
    logic          over;
    logic [CW-1:0] quotient;
  } poh_div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 1'b1;
  endfunction

endpackage

[src/poh_hist_ram.sv]
// Histogram count memory: one write port and one registered read port.
module poh_hist_ram #(
  parameter int DEPTH  = 1360,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 21
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/poh_cell_div.sv]
// Iterative cell finder: restoring division, one compare-subtract per cycle.
module poh_cell_div (
  input  logic                  clk,
  input  logic                  rst,
  input  poh_pkg::poh_div_req_t req,
  output poh_pkg::poh_div_rsp_t rsp
);
  import poh_pkg::*;

  logic             busy;
  logic             done;
  logic [LVL_W-1:0] step;
  logic [LVL_W-1:0] lvl;
  logic [CW-1:0]    rem;
  logic [CW:0]      dvs;
  logic [CW-1:0]    quot;
  logic             over;
  logic [SH_W-1:0]  shifted;
  logic             ge;

  assign shifted = SH_W'(dvs) << step;
  assign ge      = SH_W'(rem) >= shifted;

  // The first step checks that the quotient fits in level bits; the others
  // produce one quotient bit each, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy) begin
        if ((step == lvl) && ge) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      step <= req.level;
      lvl  <= req.level;
      rem  <= req.dividend;
      dvs  <= req.divisor;
      quot <= '0;
      over <= 1'b0;
    end else if (busy) begin
      if (step == lvl) begin
        if (ge) begin
          over <= 1'b1;
        end
      end else if (ge) begin
        rem  <= CW'(SH_W'(rem) - shifted);
        quot <= quot | (CW'(1) << step);
      end
      if (step != '0) begin
        step <= step - 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.over     = over;
  assign rsp.quotient = quot;

endmodule

[src/pyramid_orientation_histogram.sv]
// Top level of the spatial-pyramid orientation histogram engine.
//
//   channel | signals                          | carries
//   in      | in_valid, in_ready               | operation, point, bin, read index
//   out     | out_valid, out_ready             | count, running total, ignored flag
//   cfg     | cfg_valid, cfg_ready             | register index and data
//
// An add steps through each level up to the configured one; the two cell divisions
// of a level go in turn through the shared compare-subtract unit.
// A read fetches the count through the registered memory read port, and a clear
// sweeps the memory with zeros; after reset the same sweep runs with in_ready low.
// A finished word waits in the output register; a new item may enter meanwhile,
// and only its final load waits for out_ready. cfg_ready is always high.
module pyramid_orientation_histogram #(
  parameter int IMAGE_SIDE = 1024,
  parameter int MAX_BINS   = 16,
  parameter int MAX_LEVEL  = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [poh_pkg::OP_W-1:0]       operation,
  input  logic [poh_pkg::CW-1:0]         point_x,
  input  logic [poh_pkg::CW-1:0]         point_y,
  input  logic [poh_pkg::OB_W-1:0]       orient_bin,
  input  logic [poh_pkg::RI_W-1:0]       read_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [poh_pkg::CNT_W-1:0]      count_value,
  output logic [poh_pkg::CNT_W-1:0]      total_points,
  output logic                           point_ignored,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [poh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [poh_pkg::CW-1:0]         cfg_data
);
  import poh_pkg::*;

  localparam int CELL_TOTAL  = ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
  localparam int STORE_DEPTH = MAX_BINS * CELL_TOTAL;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CB_W        = $clog2(CELL_TOTAL + 1);
  localparam int NB_W        = $clog2(MAX_BINS + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_LEVEL  = 4'd3;
  localparam logic [3:0] S_DIVX   = 4'd4;
  localparam logic [3:0] S_DIVY   = 4'd5;
  localparam logic [3:0] S_INDEX  = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_RDITEM = 4'd10;
  localparam logic [3:0] S_RDCAP  = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  // Configuration registers.
  logic [CW-1:0]    box_left;
  logic [CW-1:0]    box_right;
  logic [CW-1:0]    box_top;
  logic [CW-1:0]    box_bottom;
  logic [BIN_W-1:0] bin_count;
  logic [LEV_W-1:0] levels;

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_item;
  logic [CW-1:0]     px;
  logic [CW-1:0]     py;
  logic [OB_W-1:0]   ob;
  logic [RI_W-1:0]   ri;
  logic [NB_W-1:0]   nb;
  logic [LVL_W-1:0]  lv;
  logic [CW:0]       w;
  logic [CW:0]       h;
  logic [CW-1:0]     rx;
  logic [CW-1:0]     ry;
  logic [LVL_W-1:0]  lvl;
  logic [CB_W-1:0]   cell_base;
  logic [CW:0]       gy;
  logic [CW-1:0]     cx;
  logic [CW-1:0]     cy;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  res_count;
  logic              res_ign;
  logic [CNT_W-1:0]  total;

  logic [CW-1:0]     right_c;
  logic [CW-1:0]     bottom_c;
  logic [NB_W-1:0]   nb_c;
  logic [LVL_W-1:0]  lv_c;
  logic              ign_c;
  logic [CW:0]       gx_c;
  logic [CW:0]       gy_c;
  logic              cell_ok;
  logic [CB_W-1:0]   cell_c;
  logic              ri_ok;
  logic              out_load;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_data;

  poh_div_req_t div_req;
  poh_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_right  <= CW'(1023);
      box_top    <= '0;
      box_bottom <= CW'(1023);
      bin_count  <= BIN_W'(8);
      levels     <= LEV_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOX_LEFT:   box_left   <= cfg_data;
        CFG_BOX_RIGHT:  box_right  <= cfg_data;
        CFG_BOX_TOP:    box_top    <= cfg_data;
        CFG_BOX_BOTTOM: box_bottom <= cfg_data;
        CFG_BIN_COUNT:  bin_count  <= cfg_data[BIN_W-1:0];
        CFG_LEVELS:     levels     <= cfg_data[LEV_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective configuration and the reject test for an added point.
  always_comb begin
    right_c  = (32'(box_right) > IMAGE_SIDE - 1) ? CW'(IMAGE_SIDE - 1) : box_right;
    bottom_c = (32'(box_bottom) > IMAGE_SIDE - 1) ? CW'(IMAGE_SIDE - 1) : box_bottom;
    nb_c     = (32'(bin_count) > MAX_BINS) ? NB_W'(MAX_BINS) : NB_W'(bin_count);
    lv_c     = (32'(levels) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : LVL_W'(levels);
    ign_c    = (nb_c == '0) || (32'(ob) >= 32'(nb_c)) ||
               (right_c < box_left) || (bottom_c < box_top) ||
               (px < box_left) || (px > right_c) ||
               (py < box_top) || (py > bottom_c);
  end

  assign gx_c    = w >> lvl;
  assign gy_c    = h >> lvl;
  assign cell_ok = (gx_c != '0) && (gy_c != '0);
  assign cell_c  = CB_W'(32'(cell_base) + (32'(cx) << lvl) + 32'(cy));
  assign ri_ok   = 32'(ri) < STORE_DEPTH;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    div_req.start    = ((state == S_LEVEL) && cell_ok) ||
                       ((state == S_DIVX) && div_rsp.done && !div_rsp.over);
    div_req.dividend = (state == S_LEVEL) ? rx : ry;
    div_req.divisor  = (state == S_LEVEL) ? gx_c : gy;
    div_req.level    = lvl;
  end

  poh_cell_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    wr_en   = (state == S_CLEAR) || (state == S_WR);
    wr_addr = (state == S_CLEAR) ? clr_addr : idx;
    wr_data = (state == S_CLEAR) ? '0 : sat_inc(rd_data);
    rd_en   = (state == S_RD) || ((state == S_RDITEM) && ri_ok);
    rd_addr = (state == S_RD) ? idx : ADDR_W'(ri);
  end

  poh_hist_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CNT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_item  <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= clr_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            px        <= point_x;
            py        <= point_y;
            ob        <= orient_bin;
            ri        <= read_index;
            res_count <= '0;
            res_ign   <= 1'b0;
            case (operation)
              OP_CLEAR: begin
                total    <= '0;
                clr_addr <= '0;
                clr_item <= 1'b1;
                state    <= S_CLEAR;
              end
              OP_ADD:  state <= S_CHECK;
              OP_READ: state <= S_RDITEM;
              default: state <= S_DONE;
            endcase
          end
        end
        S_CHECK: begin
          nb        <= nb_c;
          lv        <= lv_c;
          w         <= (CW + 1)'(right_c) - (CW + 1)'(box_left) + 1'b1;
          h         <= (CW + 1)'(bottom_c) - (CW + 1)'(box_top) + 1'b1;
          rx        <= px - box_left;
          ry        <= py - box_top;
          lvl       <= '0;
          cell_base <= '0;
          if (ign_c) begin
            res_ign <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          gy    <= gy_c;
          state <= cell_ok ? S_DIVX : S_NEXT;
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            cx    <= div_rsp.quotient;
            state <= div_rsp.over ? S_NEXT : S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            cy    <= div_rsp.quotient;
            state <= div_rsp.over ? S_NEXT : S_INDEX;
          end
        end
        S_INDEX: begin
          idx   <= ADDR_W'(32'(cell_c) * 32'(nb) + 32'(ob));
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          total <= sat_inc(total);
          state <= S_NEXT;
        end
        S_NEXT: begin
          cell_base <= cell_base + CB_W'(32'(1) << {lvl, 1'b0});
          if (lvl == lv) begin
            state <= S_DONE;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_LEVEL;
          end
        end
        S_RDITEM: begin
          state <= ri_ok ? S_RDCAP : S_DONE;
        end
        S_RDCAP: begin
          res_count <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            clr_item  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count_value   <= res_count;
      total_points  <= total;
      point_ignored <= res_ign;
    end
  end

endmodule

[src/poh_checker.sv]
// Port-level checks of the pyramid orientation histogram, bound to the top level.
module poh_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [poh_pkg::CNT_W-1:0]     count_value,
  input logic [poh_pkg::CNT_W-1:0]     total_points,
  input logic                          point_ignored
);
  import poh_pkg::*;

  // A held result word keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_value) &&
      $stable(total_points) && $stable(point_ignored))
    else $error("result word changed while stalled");

  // The memory sweep after reset keeps the input closed.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open right after reset");

  // An accepted item closes the input while the engine works on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // An ignored point never reports a stored count.
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_ignored |-> count_value == '0)
    else $error("ignored point with nonzero count");

  // Counts saturate at the limit.
  a_total_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_points <= COUNT_LIMIT) && (count_value <= COUNT_LIMIT))
    else $error("count above saturation limit");

endmodule

bind pyramid_orientation_histogram poh_checker u_poh_checker (.*);
